// File: rtl/core/mifp_pkg.sv
// ----------------------------------------------------------------------------
// mifp_pkg: shared types and widths of the minimum-image force projection
// Register codes, mode codes and the datapath widths of each pipeline stage.
// ----------------------------------------------------------------------------
package mifp_pkg;

  // Port widths.
  localparam int IN_W   = 32;  // input and result fields
  localparam int BOX_W  = 31;  // box length registers
  localparam int IDX_W  = 2;   // configuration register index

  // Datapath widths, sized by the worst case of each value.
  localparam int DIFF_W = IN_W + 1;        // second - first
  localparam int RC_W   = IN_W + 2;        // separation after the box correction
  localparam int RMAG_W = RC_W;            // magnitude of the corrected separation
  localparam int VMAG_W = IN_W;            // magnitude of a force component
  localparam int PRV_W  = RMAG_W + VMAG_W; // one term of the dot product
  localparam int PRR_W  = 2 * RMAG_W;      // one square of the separation
  localparam int PVV_W  = 2 * VMAG_W;      // one square of the force
  localparam int DOT_W  = PRV_W + 1;       // sum of three dot terms
  localparam int RR_W   = PRR_W + 2;       // sum of three separation squares
  localparam int VV_W   = PVV_W;           // sum of three force squares (fits)
  localparam int RN_W   = RR_W / 2;        // |r|
  localparam int VN_W   = VV_W / 2;        // |v|
  localparam int RREM_W = RN_W + 2;        // square root remainder for |r|
  localparam int VREM_W = VN_W + 2;        // square root remainder for |v|
  localparam int Q_W    = VN_W;            // quotient bits kept by the divider

  // Pipeline depth: five front stages, the square roots, the overflow check,
  // the divider and the output register.
  localparam int SQ_STAGES  = RN_W;
  localparam int VSQ_STAGES = VN_W;
  localparam int LATENCY    = 5 + SQ_STAGES + 1 + Q_W + 1;

  localparam logic [IN_W-1:0] MAX_POS = {1'b0, {(IN_W-1){1'b1}}};
  localparam logic [IN_W-1:0] MAX_NEG = {1'b1, {(IN_W-1){1'b0}}};

  typedef enum logic [1:0] {
    MODE_NORM  = 2'd0,
    MODE_SPROJ = 2'd1,
    MODE_UPROJ = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [IDX_W-1:0] {
    CFG_MODE  = 2'd0,
    CFG_BOX_X = 2'd1,
    CFG_BOX_Y = 2'd2,
    CFG_BOX_Z = 2'd3
  } cfg_reg_t;

endpackage

// File: rtl/core/min_image_force_projection_top.sv
// ----------------------------------------------------------------------------
// min_image_force_projection_top: pipelined minimum-image force projection
// Forms r = second - first, minimum-image corrected per axis outside UPROJ, then
// the signed norm, signed or unsigned projection of the force, or MAX_POS in NONE.
// ----------------------------------------------------------------------------
//
// Channel    Signals                                   Handshake
// --------   ---------------------------------------   -----------------------
// request    start, busy, first_*, second_*, vec_*     start && !busy
// result     done, scalar_value, saturated             done, one cycle, no stall
// config     cfg_valid, cfg_ready, cfg_index, cfg_data cfg_valid && cfg_ready
//
// The block takes one request per clock cycle while busy is low. The depth
// comes from the square root of |r|, which resolves one result bit per stage
// over 35 stages, and the divider, which resolves one quotient bit per stage
// over 32 stages.
// busy is high only during reset; cfg_ready likewise drops only during reset.
// The synchronous reset clears the configuration registers and every valid
// bit of the pipeline, so no result appears for requests before reset.
// The receiver cannot stall, so the pipeline advances on every cycle.

module min_image_force_projection_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [mifp_pkg::IN_W-1:0]    first_x,
  input  logic signed [mifp_pkg::IN_W-1:0]    first_y,
  input  logic signed [mifp_pkg::IN_W-1:0]    first_z,
  input  logic signed [mifp_pkg::IN_W-1:0]    second_x,
  input  logic signed [mifp_pkg::IN_W-1:0]    second_y,
  input  logic signed [mifp_pkg::IN_W-1:0]    second_z,
  input  logic signed [mifp_pkg::IN_W-1:0]    vec_x,
  input  logic signed [mifp_pkg::IN_W-1:0]    vec_y,
  input  logic signed [mifp_pkg::IN_W-1:0]    vec_z,
  output logic                                done,
  output logic signed [mifp_pkg::IN_W-1:0]    scalar_value,
  output logic                                saturated,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mifp_pkg::IDX_W-1:0]          cfg_index,
  input  logic [mifp_pkg::IN_W-1:0]           cfg_data
);
  import mifp_pkg::*;

  // --------------------------------------------------------------------------
  // Configuration registers.
  // --------------------------------------------------------------------------
  mode_t              mode;
  logic [BOX_W-1:0]   box_len_x;
  logic [BOX_W-1:0]   box_len_y;
  logic [BOX_W-1:0]   box_len_z;

  assign busy      = rst;
  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_NORM;
      box_len_x <= '0;
      box_len_y <= '0;
      box_len_z <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MODE:  mode      <= mode_t'(cfg_data[1:0]);
        CFG_BOX_X: box_len_x <= cfg_data[BOX_W-1:0];
        CFG_BOX_Y: box_len_y <= cfg_data[BOX_W-1:0];
        CFG_BOX_Z: box_len_z <= cfg_data[BOX_W-1:0];
        default: ;
      endcase
    end
  end

  // Magnitude of a corrected separation component; the value range keeps the
  // negation inside the width.
  function automatic logic [RMAG_W-1:0] rc_mag(input logic signed [RC_W-1:0] a);
    return a[RC_W-1] ? RMAG_W'(-a) : RMAG_W'(a);
  endfunction

  // One minimum-image correction: add the box if that shrinks the magnitude,
  // otherwise subtract it if that does.
  function automatic logic signed [RC_W-1:0] min_img(
    input logic signed [DIFF_W-1:0] r,
    input logic [BOX_W-1:0]         box
  );
    logic signed [RC_W-1:0] rx;
    logic signed [RC_W-1:0] bx;
    logic signed [RC_W-1:0] rp;
    logic signed [RC_W-1:0] rm;
    rx = RC_W'(r);
    bx = $signed({{(RC_W-BOX_W){1'b0}}, box});
    rp = rx + bx;
    rm = rx - bx;
    if (rc_mag(rp) < rc_mag(rx)) return rp;
    if (rc_mag(rm) < rc_mag(rx)) return rm;
    return rx;
  endfunction

  // --------------------------------------------------------------------------
  // Stage 1: separation.
  // --------------------------------------------------------------------------
  logic                     s1_valid;
  mode_t                    s1_mode;
  logic signed [DIFF_W-1:0] s1_r [3];
  logic signed [IN_W-1:0]   s1_v [3];

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else     s1_valid <= start && !busy;
  end

  always_ff @(posedge clk) begin
    s1_mode <= mode;
    s1_r[0] <= DIFF_W'(second_x) - DIFF_W'(first_x);
    s1_r[1] <= DIFF_W'(second_y) - DIFF_W'(first_y);
    s1_r[2] <= DIFF_W'(second_z) - DIFF_W'(first_z);
    s1_v[0] <= vec_x;
    s1_v[1] <= vec_y;
    s1_v[2] <= vec_z;
  end

  // --------------------------------------------------------------------------
  // Stage 2: box correction (not in the unsigned mode), magnitudes and signs.
  // --------------------------------------------------------------------------
  logic               s2_valid;
  mode_t              s2_mode;
  logic [RMAG_W-1:0]  s2_rmag [3];
  logic [VMAG_W-1:0]  s2_vmag [3];
  logic               s2_rneg [3];
  logic               s2_vneg [3];
  logic signed [RC_W-1:0] s2_rc [3];

  always_comb begin
    if (s1_mode == MODE_UPROJ) begin
      s2_rc[0] = RC_W'(s1_r[0]);
      s2_rc[1] = RC_W'(s1_r[1]);
      s2_rc[2] = RC_W'(s1_r[2]);
    end else begin
      s2_rc[0] = min_img(s1_r[0], box_len_x);
      s2_rc[1] = min_img(s1_r[1], box_len_y);
      s2_rc[2] = min_img(s1_r[2], box_len_z);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) s2_valid <= 1'b0;
    else     s2_valid <= s1_valid;
  end

  always_ff @(posedge clk) begin
    s2_mode <= s1_mode;
    for (int k = 0; k < 3; k++) begin
      s2_rmag[k] <= rc_mag(s2_rc[k]);
      s2_rneg[k] <= s2_rc[k][RC_W-1];
      s2_vmag[k] <= s1_v[k][IN_W-1] ? VMAG_W'(0 - s1_v[k]) : VMAG_W'(s1_v[k]);
      s2_vneg[k] <= s1_v[k][IN_W-1];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: products, one multiplier per term.
  // --------------------------------------------------------------------------
  logic              s3_valid;
  mode_t             s3_mode;
  logic [PRV_W-1:0]  s3_prv [3];
  logic              s3_sgn [3];
  logic [PRR_W-1:0]  s3_prr [3];
  logic [PVV_W-1:0]  s3_pvv [3];

  always_ff @(posedge clk) begin
    if (rst) s3_valid <= 1'b0;
    else     s3_valid <= s2_valid;
  end

  always_ff @(posedge clk) begin
    s3_mode <= s2_mode;
    for (int k = 0; k < 3; k++) begin
      s3_prv[k] <= PRV_W'(s2_rmag[k]) * PRV_W'(s2_vmag[k]);
      s3_sgn[k] <= s2_rneg[k] ^ s2_vneg[k];
      s3_prr[k] <= PRR_W'(s2_rmag[k]) * PRR_W'(s2_rmag[k]);
      s3_pvv[k] <= PVV_W'(s2_vmag[k]) * PVV_W'(s2_vmag[k]);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: sums. Dot terms are split by sign into two unsigned sums.
  // --------------------------------------------------------------------------
  logic              s4_valid;
  mode_t             s4_mode;
  logic [DOT_W-1:0]  s4_pos;
  logic [DOT_W-1:0]  s4_neg;
  logic [RR_W-1:0]   s4_rr;
  logic [VV_W-1:0]   s4_vv;
  logic [DOT_W-1:0]  s4_pos_next;
  logic [DOT_W-1:0]  s4_neg_next;

  always_comb begin
    s4_pos_next = '0;
    s4_neg_next = '0;
    for (int k = 0; k < 3; k++) begin
      if (s3_sgn[k]) s4_neg_next = s4_neg_next + DOT_W'(s3_prv[k]);
      else           s4_pos_next = s4_pos_next + DOT_W'(s3_prv[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) s4_valid <= 1'b0;
    else     s4_valid <= s3_valid;
  end

  always_ff @(posedge clk) begin
    s4_mode <= s3_mode;
    s4_pos  <= s4_pos_next;
    s4_neg  <= s4_neg_next;
    s4_rr   <= RR_W'(s3_prr[0]) + RR_W'(s3_prr[1]) + RR_W'(s3_prr[2]);
    s4_vv   <= VV_W'(s3_pvv[0]) + VV_W'(s3_pvv[1]) + VV_W'(s3_pvv[2]);
  end

  // --------------------------------------------------------------------------
  // Stage 5: sign and magnitude of the dot product.
  // --------------------------------------------------------------------------
  logic              s5_valid;
  mode_t             s5_mode;
  logic              s5_dpos;
  logic              s5_dneg;
  logic [DOT_W-1:0]  s5_dmag;
  logic [RR_W-1:0]   s5_rr;
  logic [VV_W-1:0]   s5_vv;

  always_ff @(posedge clk) begin
    if (rst) s5_valid <= 1'b0;
    else     s5_valid <= s4_valid;
  end

  always_ff @(posedge clk) begin
    s5_mode <= s4_mode;
    s5_dpos <= s4_pos > s4_neg;
    s5_dneg <= s4_pos < s4_neg;
    s5_dmag <= (s4_pos > s4_neg) ? s4_pos - s4_neg : s4_neg - s4_pos;
    s5_rr   <= s4_rr;
    s5_vv   <= s4_vv;
  end

  // --------------------------------------------------------------------------
  // Square root pipelines: one result bit per stage. |v| finishes early and
  // then rides along with |r|.
  // --------------------------------------------------------------------------
  logic              sq_valid [0:SQ_STAGES];
  mode_t             sq_mode  [0:SQ_STAGES];
  logic              sq_dpos  [0:SQ_STAGES];
  logic              sq_dneg  [0:SQ_STAGES];
  logic [DOT_W-1:0]  sq_dmag  [0:SQ_STAGES];
  logic [RR_W-1:0]   sr_opd   [0:SQ_STAGES];
  logic [RREM_W-1:0] sr_rem   [0:SQ_STAGES];
  logic [RN_W-1:0]   sr_res   [0:SQ_STAGES];
  logic [VV_W-1:0]   sv_opd   [0:SQ_STAGES];
  logic [VREM_W-1:0] sv_rem   [0:SQ_STAGES];
  logic [VN_W-1:0]   sv_res   [0:SQ_STAGES];

  always_comb begin
    sq_valid[0] = s5_valid;
    sq_mode[0]  = s5_mode;
    sq_dpos[0]  = s5_dpos;
    sq_dneg[0]  = s5_dneg;
    sq_dmag[0]  = s5_dmag;
    sr_opd[0]   = s5_rr;
    sr_rem[0]   = '0;
    sr_res[0]   = '0;
    sv_opd[0]   = s5_vv;
    sv_rem[0]   = '0;
    sv_res[0]   = '0;
  end

  for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sqrt
    logic [RREM_W+1:0] r_cur;
    logic [RN_W+1:0]   r_try;
    logic              r_ge;

    assign r_cur = {sr_rem[k], sr_opd[k][RR_W-1 -: 2]};
    assign r_try = {sr_res[k], 2'b01};
    assign r_ge  = r_cur >= {{(RREM_W-RN_W){1'b0}}, r_try};

    always_ff @(posedge clk) begin
      if (rst) sq_valid[k+1] <= 1'b0;
      else     sq_valid[k+1] <= sq_valid[k];
    end

    always_ff @(posedge clk) begin
      sq_mode[k+1] <= sq_mode[k];
      sq_dpos[k+1] <= sq_dpos[k];
      sq_dneg[k+1] <= sq_dneg[k];
      sq_dmag[k+1] <= sq_dmag[k];
      sr_opd[k+1]  <= sr_opd[k] << 2;
      sr_rem[k+1]  <= r_ge ? RREM_W'(r_cur - {{(RREM_W-RN_W){1'b0}}, r_try})
                           : RREM_W'(r_cur);
      sr_res[k+1]  <= {sr_res[k][RN_W-2:0], r_ge};
    end

    if (k < VSQ_STAGES) begin : g_vsq
      logic [VREM_W+1:0] v_cur;
      logic [VN_W+1:0]   v_try;
      logic              v_ge;

      assign v_cur = {sv_rem[k], sv_opd[k][VV_W-1 -: 2]};
      assign v_try = {sv_res[k], 2'b01};
      assign v_ge  = v_cur >= {{(VREM_W-VN_W){1'b0}}, v_try};

      always_ff @(posedge clk) begin
        sv_opd[k+1] <= sv_opd[k] << 2;
        sv_rem[k+1] <= v_ge ? VREM_W'(v_cur - {{(VREM_W-VN_W){1'b0}}, v_try})
                            : VREM_W'(v_cur);
        sv_res[k+1] <= {sv_res[k][VN_W-2:0], v_ge};
      end
    end else begin : g_vhold
      always_ff @(posedge clk) begin
        sv_opd[k+1] <= sv_opd[k];
        sv_rem[k+1] <= sv_rem[k];
        sv_res[k+1] <= sv_res[k];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Divider: an overflow check against |r| << Q_W, then one quotient bit per
  // stage. A quotient of Q_W bits or more always exceeds |v|, so it clamps.
  // --------------------------------------------------------------------------
  logic              dv_valid [0:Q_W];
  mode_t             dv_mode  [0:Q_W];
  logic              dv_dpos  [0:Q_W];
  logic              dv_dneg  [0:Q_W];
  logic              dv_ovf   [0:Q_W];
  logic [VN_W-1:0]   dv_vnorm [0:Q_W];
  logic [RN_W-1:0]   dv_rnorm [0:Q_W];
  logic [RN_W-1:0]   dv_rem   [0:Q_W];
  logic [Q_W-1:0]    dv_low   [0:Q_W];
  logic [Q_W-1:0]    dv_q     [0:Q_W];

  always_ff @(posedge clk) begin
    if (rst) dv_valid[0] <= 1'b0;
    else     dv_valid[0] <= sq_valid[SQ_STAGES];
  end

  always_ff @(posedge clk) begin
    dv_mode[0]  <= sq_mode[SQ_STAGES];
    dv_dpos[0]  <= sq_dpos[SQ_STAGES];
    dv_dneg[0]  <= sq_dneg[SQ_STAGES];
    dv_ovf[0]   <= sq_dmag[SQ_STAGES] >= {sr_res[SQ_STAGES], {Q_W{1'b0}}};
    dv_vnorm[0] <= sv_res[SQ_STAGES];
    dv_rnorm[0] <= sr_res[SQ_STAGES];
    dv_rem[0]   <= sq_dmag[SQ_STAGES][DOT_W-1 -: RN_W];
    dv_low[0]   <= sq_dmag[SQ_STAGES][Q_W-1:0];
    dv_q[0]     <= '0;
  end

  for (genvar j = 0; j < Q_W; j++) begin : g_div
    logic [RN_W:0] t;
    logic          ge;

    assign t  = {dv_rem[j], dv_low[j][Q_W-1]};
    assign ge = t >= {1'b0, dv_rnorm[j]};

    always_ff @(posedge clk) begin
      if (rst) dv_valid[j+1] <= 1'b0;
      else     dv_valid[j+1] <= dv_valid[j];
    end

    always_ff @(posedge clk) begin
      dv_mode[j+1]  <= dv_mode[j];
      dv_dpos[j+1]  <= dv_dpos[j];
      dv_dneg[j+1]  <= dv_dneg[j];
      dv_ovf[j+1]   <= dv_ovf[j];
      dv_vnorm[j+1] <= dv_vnorm[j];
      dv_rnorm[j+1] <= dv_rnorm[j];
      dv_rem[j+1]   <= ge ? RN_W'(t - {1'b0, dv_rnorm[j]}) : RN_W'(t);
      dv_low[j+1]   <= dv_low[j] << 1;
      dv_q[j+1]     <= {dv_q[j][Q_W-2:0], ge};
    end
  end

  // --------------------------------------------------------------------------
  // Output stage: select the magnitude and sign, then saturate.
  // --------------------------------------------------------------------------
  logic [VN_W-1:0] fin_vn;
  logic [VN_W-1:0] fin_mag;
  logic            fin_neg;
  logic            fin_fixed;
  logic [IN_W-1:0] fin_value;
  logic            fin_sat;

  assign fin_vn = dv_vnorm[Q_W];

  always_comb begin
    fin_fixed = 1'b0;
    fin_mag   = '0;
    fin_neg   = 1'b0;
    if (dv_mode[Q_W] == MODE_NONE) begin
      fin_fixed = 1'b1;
    end else if (dv_rnorm[Q_W] == '0 || fin_vn == '0) begin
      // A zero separation or force counts as a cosine of one.
      fin_mag = fin_vn;
      fin_neg = dv_mode[Q_W] != MODE_UPROJ;
    end else if (dv_mode[Q_W] == MODE_NORM) begin
      if (dv_dpos[Q_W] || dv_dneg[Q_W]) fin_mag = fin_vn;
      fin_neg = dv_dpos[Q_W];
    end else begin
      // The clamp to |v| stands in for limiting the cosine to one.
      fin_mag = (dv_ovf[Q_W] || dv_q[Q_W] > fin_vn) ? fin_vn : dv_q[Q_W];
      fin_neg = (dv_mode[Q_W] == MODE_SPROJ) && dv_dpos[Q_W];
    end

    if (fin_fixed) begin
      fin_value = MAX_POS;
      fin_sat   = 1'b1;
    end else if (fin_neg) begin
      fin_sat   = fin_mag[VN_W-1] && (fin_mag[VN_W-2:0] != '0);
      fin_value = fin_sat ? MAX_NEG : IN_W'(0 - fin_mag);
    end else begin
      fin_sat   = fin_mag[VN_W-1];
      fin_value = fin_sat ? MAX_POS : IN_W'(fin_mag);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= dv_valid[Q_W];
  end

  always_ff @(posedge clk) begin
    scalar_value <= $signed(fin_value);
    saturated    <= fin_sat;
  end

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  a_latency: assert property (@(posedge clk) disable iff (rst)
    1'b1 |-> done == $past(start && !busy, LATENCY))
    else $error("result strobe does not match a request accepted LATENCY ago");

  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    done && saturated |-> scalar_value == MAX_POS || scalar_value == MAX_NEG)
    else $error("saturated result is not a range limit");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    dv_valid[Q_W] && !dv_ovf[Q_W] && dv_rnorm[Q_W] != '0
      |-> dv_rem[Q_W] < dv_rnorm[Q_W])
    else $error("divider remainder not below the divisor");

  a_dot_sign: assert property (@(posedge clk) disable iff (rst)
    s5_valid |=> !(sq_dpos[1] && sq_dneg[1]) && (sq_dmag[1] == '0) == !(sq_dpos[1] || sq_dneg[1]))
    else $error("dot product sign flags disagree with its magnitude");

endmodule
